/* rtl/coordinate_frame_to_angle_error_defines.svh */
// assertion macros for the coordinate frame to angle error block
// used by rtl/coordinate_frame_to_angle_error.sv
`ifndef COORDINATE_FRAME_TO_ANGLE_ERROR_DEFINES_SVH
`define COORDINATE_FRAME_TO_ANGLE_ERROR_DEFINES_SVH
`ifndef SYNTH
`define CFAE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CFAE_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CFAE_ASSERT(label, clk, rst_n, prop)
`define CFAE_ASSERT_NR(label, clk, prop)
`endif
`endif

/* rtl/cfae_pkg.sv */
// package for the coordinate frame to angle error block
// types, constants and the arctangent table; no dependencies
`timescale 1ns / 1ps
package cfae_pkg;
  localparam int FrameBytes = 64;
  localparam int CordicSteps = 16;
  localparam int MaxSteps = 24;
  localparam int UsedSteps = (CordicSteps > MaxSteps) ? MaxSteps : CordicSteps;
  localparam int PosW = $clog2(FrameBytes + 1);
  localparam int StepW = $clog2(UsedSteps + 1);
  localparam logic [15:0] RightAngleQ8 = 16'd23040;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [1:0] RegTrack = 2'd0;
  localparam logic [1:0] RegDist = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  typedef enum logic [1:0] {PH_START, PH_SIGN, PH_DIGITS} phase_e;
  typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_ITER, ST_DONE, ST_DIST, ST_OUT} state_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic               angles_valid;
    logic               led_off;
  } out_t;

  function automatic logic [22:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_q16 = 23'd2949120;  5'd1: atan_q16 = 23'd1740967;
      5'd2: atan_q16 = 23'd919879;   5'd3: atan_q16 = 23'd466945;
      5'd4: atan_q16 = 23'd234379;   5'd5: atan_q16 = 23'd117305;
      5'd6: atan_q16 = 23'd58666;    5'd7: atan_q16 = 23'd29335;
      5'd8: atan_q16 = 23'd14668;    5'd9: atan_q16 = 23'd7334;
      5'd10: atan_q16 = 23'd3667;    5'd11: atan_q16 = 23'd1833;
      5'd12: atan_q16 = 23'd917;     5'd13: atan_q16 = 23'd458;
      5'd14: atan_q16 = 23'd229;     5'd15: atan_q16 = 23'd115;
      5'd16: atan_q16 = 23'd57;      5'd17: atan_q16 = 23'd29;
      5'd18: atan_q16 = 23'd14;      5'd19: atan_q16 = 23'd7;
      5'd20: atan_q16 = 23'd4;       5'd21: atan_q16 = 23'd2;
      5'd22: atan_q16 = 23'd1;
      default: atan_q16 = 23'd0;
    endcase
  endfunction
endpackage

/* rtl/coordinate_frame_to_angle_error.sv */
// top level of the coordinate frame to angle error block
// depends on cfae_pkg and coordinate_frame_to_angle_error_defines.svh
`timescale 1ns / 1ps
`include "coordinate_frame_to_angle_error_defines.svh"
// Parses "G x1,y1,x2,y2" frames one byte beat at a time and, on the frame end
// beat of a 'G' frame, gives one result beat. Ordinary bytes are taken while
// the sequencer is idle. The frame end beat of a 'G' frame starts a sequencer
// around one shared CORDIC datapath. In tracking mode it runs four angles, each
// through a load state, CordicSteps iterations and a finish state. A distance
// state follows for the squared distance and radius on 16x16 multipliers, and
// the output state registers the result. Outside tracking mode only the output
// state is used. Input ready is low meanwhile. The result sits in an output
// register and the next byte is taken while it waits. Frames not starting with
// 'G' give no result.
module coordinate_frame_to_angle_error
  import cfae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  // configuration
  logic [7:0]  track_q;
  logic [15:0] dist_q, radius_q;
  // parser state
  logic [PosW-1:0] pos_q;
  logic        marked_q, neg_q, stop_q;
  logic [2:0]  field_q;
  phase_e      phase_q;
  logic [15:0] acc_q;
  logic [15:0] coord_q [4];
  // sequencer
  state_e      state_q, state_d;
  logic [1:0]  ang_q;
  logic [StepW-1:0] step_q;
  logic signed [19:0] cx_q, cy_q;
  logic signed [24:0] cz_q;
  logic [15:0] ang_res_q [4];
  logic signed [16:0] dx_q, dy_q;
  logic [33:0] sq_q;
  logic [31:0] r2_q;
  logic        out_valid_q;
  out_t        out_q;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= '0;
      dist_q <= 16'd1000;
      radius_q <= 16'd30;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegTrack: track_q <= cfg_data_i[7:0];
        RegDist: dist_q <= cfg_data_i;
        RegRadius: radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // byte classification and parse step
  logic [7:0] b;
  logic digit, space;
  logic [15:0] dval, acc10, store_val;
  assign b = in_data_i.rx_byte;
  assign digit = (b >= ChZero) && (b <= ChNine);
  assign space = (b == ChSpace) || ((b >= 8'd9) && (b <= 8'd13));
  assign dval = {12'd0, 4'(b - ChZero)};
  assign acc10 = 16'({acc_q, 3'b0} + {acc_q, 1'b0} + dval);
  assign store_val = neg_q ? 16'(-acc_q) : acc_q;

  logic        p_stop, p_neg, p_store;
  phase_e      p_phase;
  logic [15:0] p_acc;
  logic        parse_en;
  always_comb begin
    p_stop = stop_q; p_neg = neg_q; p_phase = phase_q; p_acc = acc_q; p_store = 1'b0;
    parse_en = (pos_q < PosW'(FrameBytes)) && (pos_q != '0) && marked_q && !stop_q;
    if (parse_en) begin
      case (phase_q)
        PH_START: begin
          if (space) begin
          end else if (b == ChPlus || b == ChMinus) begin
            p_neg = (b == ChMinus); p_phase = PH_SIGN;
          end else if (digit) begin
            p_neg = 1'b0; p_acc = dval; p_phase = PH_DIGITS;
          end else p_stop = 1'b1;
        end
        PH_SIGN: begin
          if (digit) begin
            p_acc = dval; p_phase = PH_DIGITS;
          end else p_stop = 1'b1;
        end
        PH_DIGITS: begin
          if (digit) p_acc = acc10;
          else begin
            p_store = 1'b1;
            if (field_q == 3'd3 || b != ChComma) p_stop = 1'b1;
            else begin
              p_phase = PH_START; p_neg = 1'b0;
            end
          end
        end
        default: p_stop = 1'b1;
      endcase
    end
  end

  // frame end completion of a pending number
  logic end_store;
  logic marked_now;
  assign marked_now = (pos_q == '0) ? (b == ChG) : marked_q;
  assign end_store = marked_now && !p_stop && (p_phase == PH_DIGITS) && !p_store;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; marked_q <= 1'b0; neg_q <= 1'b0; stop_q <= 1'b0;
      field_q <= '0; phase_q <= PH_START; acc_q <= '0;
      for (int i = 0; i < 4; i++) coord_q[i] <= '0;
    end else if (in_acc) begin
      if (p_store) coord_q[field_q[1:0]] <= store_val;
      if (in_data_i.frame_end) begin
        // pending number at frame end: p_acc and p_neg hold it
        if (end_store) coord_q[field_q[1:0]] <= p_neg ? 16'(-p_acc) : p_acc;
        pos_q <= '0; marked_q <= 1'b0; neg_q <= 1'b0; stop_q <= 1'b0;
        field_q <= '0; phase_q <= PH_START; acc_q <= '0;
      end else begin
        if (pos_q < PosW'(FrameBytes)) begin
          pos_q <= pos_q + 1'b1;
          if (pos_q == '0) marked_q <= (b == ChG);
        end
        neg_q <= p_neg; stop_q <= p_stop; phase_q <= p_phase; acc_q <= p_acc;
        if (p_store) field_q <= field_q + 1'b1;
      end
    end
  end

  // shared cordic datapath
  logic [15:0] cur_v;
  logic signed [19:0] xs, ys;
  logic signed [24:0] zr;
  logic [22:0] at;
  logic [15:0] adx, ady;
  assign cur_v = coord_q[ang_q];
  assign xs = cx_q >>> step_q;
  assign ys = cy_q >>> step_q;
  assign at = atan_q16(5'(step_q));
  assign zr = (cz_q + 25'sd128) >>> 8;
  // distance components as magnitudes, so the squares stay 16x16
  assign adx = dx_q[16] ? 16'(-dx_q) : dx_q[15:0];
  assign ady = dy_q[16] ? 16'(-dy_q) : dy_q[15:0];

  logic go;
  assign go = in_acc && in_data_i.frame_end && marked_now;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (go) state_d = (track_q == 8'd1) ? ST_LOAD : ST_OUT;
      ST_LOAD: state_d = ST_ITER;
      ST_ITER: if (step_q == StepW'(UsedSteps - 1)) state_d = ST_DONE;
      ST_DONE: state_d = (ang_q == 2'd3) ? ST_DIST : ST_LOAD;
      ST_DIST: state_d = ST_OUT;
      ST_OUT: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q <= '0; step_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin ang_q <= '0; step_q <= '0; end
        ST_LOAD: step_q <= '0;
        ST_ITER: step_q <= step_q + 1'b1;
        ST_DONE: ang_q <= ang_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        cx_q <= {4'd0, dist_q}; cy_q <= {4'd0, cur_v}; cz_q <= '0;
      end
      ST_ITER: begin
        if (cy_q >= 0) begin
          cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + 25'(at);
        end else begin
          cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - 25'(at);
        end
      end
      ST_DONE: begin
        // zero coordinate and zero distance special cases, then clamp
        if (cur_v == '0) ang_res_q[ang_q] <= '0;
        else if (dist_q == '0) ang_res_q[ang_q] <= RightAngleQ8;
        else if (zr < 0) ang_res_q[ang_q] <= '0;
        else if (zr > $signed({9'd0, RightAngleQ8})) ang_res_q[ang_q] <= RightAngleQ8;
        else ang_res_q[ang_q] <= zr[15:0];
        dx_q <= $signed({1'b0, coord_q[0]}) - $signed({1'b0, coord_q[2]});
        dy_q <= $signed({1'b0, coord_q[1]}) - $signed({1'b0, coord_q[3]});
        sq_q <= '0;
      end
      ST_DIST: begin
        sq_q <= 34'({16'd0, adx} * {16'd0, adx}) + 34'({16'd0, ady} * {16'd0, ady});
        r2_q <= radius_q * radius_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      if (track_q == 8'd1) begin
        out_q.angle_x <= $signed(ang_res_q[2] - ang_res_q[0]);
        out_q.angle_y <= $signed(ang_res_q[3] - ang_res_q[1]);
        out_q.angles_valid <= 1'b1;
        out_q.led_off <= (sq_q >= {2'b0, r2_q});
      end else begin
        out_q.angle_x <= '0; out_q.angle_y <= '0;
        out_q.angles_valid <= 1'b0; out_q.led_off <= 1'b1;
      end
    end
  end

  `CFAE_ASSERT(a_busy_not_ready, clk_i, rst_ni, (state_q != ST_IDLE) |-> !in_ready_o)
  `CFAE_ASSERT(a_iter_bound, clk_i, rst_ni, (state_q == ST_ITER) |-> (step_q < StepW'(UsedSteps)))
  `CFAE_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_data_o))
  `CFAE_ASSERT(a_go_starts, clk_i, rst_ni, go |=> (state_q != ST_IDLE))
endmodule
